[hw/rtl/pfba_pkg.sv]
// Shared types and constants for the per-pixel Fourier bin accumulator.
package pfba_pkg;

    localparam int PIXEL_COUNT_DEF = 16384;
    localparam int ACC_WIDTH_DEF   = 48;

    localparam int IDX_W     = 14;
    localparam int PIX_W     = 16;
    localparam int WGT_W     = 16;
    localparam int PROD_W    = WGT_W + PIX_W + 1;
    localparam int OUT_ACC_W = 48;
    localparam int SUM_W     = 32;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        logic acc;
        logic rd;
        logic clr;
    } op_t;

endpackage

[hw/rtl/per_pixel_fourier_bin_accumulator.sv]
// Top level of the per-pixel Fourier bin accumulator.
//
// Usage:
//   Command channel: a word is taken at a rising edge with start high and
//   busy low. busy never rises, so one word can be taken every cycle.
//   kind selects accumulate, read or clear for the entry at pixel_index.
//   Accumulate adds cos_weight*pixel_value to real_sum, subtracts
//   sin_weight*pixel_value from imag_sum and adds pixel_value to plain_sum,
//   each saturating. Clear zeroes the entry. Indices at or above PIXEL_COUNT
//   are ignored; a read there returns zero sums. Kind 3 is ignored.
//   Result channel: a read gives one word, shown for one cycle with done
//   high, from the result registers that follow stage 1. The receiver cannot stall.
//   Throughput is one word per cycle: the entry is read from the memory at
//   the command edge and written back in the cycle after; a same-entry access
//   in the next command is served from the write-back register.
//   Reset clears the pipeline only; memory entries hold nothing defined
//   until cleared, and no clearing pass runs.
module per_pixel_fourier_bin_accumulator #(
    parameter int PIXEL_COUNT = pfba_pkg::PIXEL_COUNT_DEF,
    parameter int ACC_WIDTH   = pfba_pkg::ACC_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [1:0]                     kind,
    input  logic        [pfba_pkg::IDX_W-1:0]     pixel_index,
    input  logic        [pfba_pkg::PIX_W-1:0]     pixel_value,
    input  logic signed [pfba_pkg::WGT_W-1:0]     cos_weight,
    input  logic signed [pfba_pkg::WGT_W-1:0]     sin_weight,
    output logic                                  done,
    output logic        [pfba_pkg::IDX_W-1:0]     entry_index,
    output logic signed [pfba_pkg::OUT_ACC_W-1:0] real_sum,
    output logic signed [pfba_pkg::OUT_ACC_W-1:0] imag_sum,
    output logic        [pfba_pkg::SUM_W-1:0]     plain_sum
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int DW = 2 * ACC_WIDTH + pfba_pkg::SUM_W;
    localparam int PW = pfba_pkg::PROD_W;

    logic                 accept;
    pfba_pkg::op_t        op_in;
    logic [31:0]          idx_wide;
    logic                 ok_in;
    logic [AW-1:0]        addr_in;

    logic                 s1_valid_reg;
    pfba_pkg::op_t        s1_op_reg;
    logic                 s1_ok_reg;
    logic [pfba_pkg::IDX_W-1:0] s1_idx_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic [pfba_pkg::PIX_W-1:0] s1_pix_reg;
    logic signed [PW-1:0] s1_pre_reg;
    logic signed [PW-1:0] s1_pim_reg;

    logic                 wb_valid_reg;
    logic [AW-1:0]        wb_addr_reg;
    logic [DW-1:0]        wb_data_reg;

    logic [DW-1:0]        rd_data;
    logic [DW-1:0]        old_entry;
    logic [DW-1:0]        new_entry;
    logic                 wr_en;

    logic signed [ACC_WIDTH-1:0]  old_real;
    logic signed [ACC_WIDTH-1:0]  old_imag;
    logic [pfba_pkg::SUM_W-1:0]   old_sum;
    logic signed [ACC_WIDTH-1:0]  new_real;
    logic signed [ACC_WIDTH-1:0]  new_imag;
    logic [pfba_pkg::SUM_W-1:0]   new_sum;
    logic signed [63:0]           real_ext;
    logic signed [63:0]           imag_ext;

    logic                          done_reg;
    logic                          done_next;
    logic [pfba_pkg::IDX_W-1:0]    entry_index_reg;
    logic signed [pfba_pkg::OUT_ACC_W-1:0] real_sum_reg;
    logic signed [pfba_pkg::OUT_ACC_W-1:0] imag_sum_reg;
    logic [pfba_pkg::SUM_W-1:0]    plain_sum_reg;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign idx_wide = 32'(pixel_index);
    assign ok_in    = idx_wide < 32'(PIXEL_COUNT);
    assign addr_in  = idx_wide[AW-1:0];

    always_comb
    begin
        op_in = '0;
        unique case (kind)
            pfba_pkg::KIND_ACC:   op_in.acc = 1'b1;
            pfba_pkg::KIND_READ:  op_in.rd  = 1'b1;
            pfba_pkg::KIND_CLEAR: op_in.clr = 1'b1;
            default:              op_in     = '0;
        endcase
    end

    // stage 1: capture command, issue read, form products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_op_reg    <= accept ? op_in : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg   <= ok_in;
            s1_idx_reg  <= pixel_index;
            s1_addr_reg <= addr_in;
            s1_pix_reg  <= pixel_value;
            s1_pre_reg  <= cos_weight * $signed({1'b0, pixel_value});
            s1_pim_reg  <= sin_weight * $signed({1'b0, pixel_value});
        end
    end

    pfba_mem #(
        .DEPTH (PIXEL_COUNT),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (new_entry),
        .rd_en   (accept),
        .rd_addr (addr_in),
        .rd_data (rd_data)
    );

    // write-back forwarding for back-to-back hits on one entry
    assign old_entry = (wb_valid_reg && wb_addr_reg == s1_addr_reg) ? wb_data_reg : rd_data;
    assign old_real  = old_entry[DW-1 -: ACC_WIDTH];
    assign old_imag  = old_entry[pfba_pkg::SUM_W +: ACC_WIDTH];
    assign old_sum   = old_entry[pfba_pkg::SUM_W-1:0];

    pfba_update #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_update (
        .clear    (s1_op_reg.clr),
        .old_real (old_real),
        .old_imag (old_imag),
        .old_sum  (old_sum),
        .prod_re  (s1_pre_reg),
        .prod_im  (s1_pim_reg),
        .pix      (s1_pix_reg),
        .new_real (new_real),
        .new_imag (new_imag),
        .new_sum  (new_sum)
    );

    assign new_entry = {new_real, new_imag, new_sum};
    assign wr_en     = s1_valid_reg && s1_ok_reg && (s1_op_reg.acc || s1_op_reg.clr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= new_entry;
        end
    end

    // result word
    assign done_next = s1_valid_reg && s1_op_reg.rd;
    assign real_ext  = 64'(old_real);
    assign imag_ext  = 64'(old_imag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            entry_index_reg <= s1_idx_reg;
            real_sum_reg    <= s1_ok_reg ? real_ext[pfba_pkg::OUT_ACC_W-1:0] : '0;
            imag_sum_reg    <= s1_ok_reg ? imag_ext[pfba_pkg::OUT_ACC_W-1:0] : '0;
            plain_sum_reg   <= s1_ok_reg ? old_sum : '0;
        end
    end

    assign done        = done_reg;
    assign entry_index = entry_index_reg;
    assign real_sum    = real_sum_reg;
    assign imag_sum    = imag_sum_reg;
    assign plain_sum   = plain_sum_reg;

    a_read_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == pfba_pkg::KIND_READ |-> ##2 (done && entry_index == $past(pixel_index, 2)))
        else $error("read command did not produce a result word");

    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && kind == pfba_pkg::KIND_READ) |-> ##2 !done)
        else $error("result word without a read command");

    a_wb_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> wb_valid_reg && wb_addr_reg == $past(s1_addr_reg))
        else $error("write-back register lost a memory write");

    a_write_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> $past(accept))
        else $error("memory write without a command one cycle earlier");

endmodule

[hw/rtl/pfba_mem.sv]
// Single-port-write, registered-read memory holding the per-pixel accumulators.
module pfba_mem #(
    parameter int DEPTH = pfba_pkg::PIXEL_COUNT_DEF,
    parameter int AW    = pfba_pkg::IDX_W,
    parameter int DW    = 2 * pfba_pkg::ACC_WIDTH_DEF + pfba_pkg::SUM_W
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/pfba_update.sv]
// Saturating update of one entry: weighted real/imag sums and plain pixel sum.
module pfba_update #(
    parameter int ACC_WIDTH = pfba_pkg::ACC_WIDTH_DEF
) (
    input  logic                                clear,
    input  logic signed [ACC_WIDTH-1:0]         old_real,
    input  logic signed [ACC_WIDTH-1:0]         old_imag,
    input  logic        [pfba_pkg::SUM_W-1:0]   old_sum,
    input  logic signed [pfba_pkg::PROD_W-1:0]  prod_re,
    input  logic signed [pfba_pkg::PROD_W-1:0]  prod_im,
    input  logic        [pfba_pkg::PIX_W-1:0]   pix,
    output logic signed [ACC_WIDTH-1:0]         new_real,
    output logic signed [ACC_WIDTH-1:0]         new_imag,
    output logic        [pfba_pkg::SUM_W-1:0]   new_sum
);

    localparam int AX = ACC_WIDTH + 1;
    localparam int SX = pfba_pkg::SUM_W + 1;

    logic signed [AX-1:0] re_wide;
    logic signed [AX-1:0] im_wide;
    logic        [SX-1:0] sum_wide;

    function automatic logic [ACC_WIDTH-1:0] sat(input logic [AX-1:0] v);
        logic [ACC_WIDTH-1:0] r;
        if (v[AX-1] != v[AX-2])
        begin
            r = v[AX-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        else
        begin
            r = v[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        re_wide  = AX'(old_real) + AX'(prod_re);
        im_wide  = AX'(old_imag) - AX'(prod_im);
        sum_wide = SX'(old_sum) + SX'(pix);
        if (clear)
        begin
            new_real = '0;
            new_imag = '0;
            new_sum  = '0;
        end
        else
        begin
            new_real = sat(re_wide);
            new_imag = sat(im_wide);
            new_sum  = sum_wide[SX-1] ? '1 : sum_wide[pfba_pkg::SUM_W-1:0];
        end
    end

endmodule
